// ----- src/enveloped_sine_tone_generator_top_assert.svh -----
// Assertion macros shared by the tone generator modules.
// Both sample on clk and are switched off while rst_n is low.
`ifndef ENVELOPED_SINE_TONE_GENERATOR_TOP_ASSERT_SVH
`define ENVELOPED_SINE_TONE_GENERATOR_TOP_ASSERT_SVH

// cond must hold at every edge
`define ESTG_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// cons must hold at the same edge whenever ante holds
`define ESTG_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ----- src/estg_pkg.sv -----
`default_nettype none

package estg_pkg;

    // opcodes (tuser of the input stream)
    localparam logic OP_START = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    localparam int AUDIO_RATE_HZ   = 16000;
    localparam int FREQ_MAX        = 8000;
    localparam int SINE_TABLE_BITS = 8;
    localparam int TBL_N           = 1 << SINE_TABLE_BITS;
    localparam int TBL_AW          = SINE_TABLE_BITS + 1;
    localparam int RAMP_LOG2       = 5;
    localparam int RAMP_SAMPLES    = 1 << RAMP_LOG2;

    // field widths
    localparam int FREQ_W   = 13;
    localparam int DUR_W    = 16;
    localparam int AMP_W    = 15;
    localparam int SAMPLE_W = 16;
    localparam int IDX_W    = 20;
    localparam int PHASE_W  = 32;
    localparam int MAG_W    = 15;
    localparam int ENV_W    = RAMP_LOG2 + 1;
    localparam int IN_W     = FREQ_W + DUR_W + AMP_W;
    localparam int IN_BYTES_W = ((IN_W + 7) / 8) * 8;

    // amplitude and envelope scaling: Q15 sine and ramp denominator
    localparam int PROD1_W     = MAG_W + AMP_W;
    localparam int PROD2_W     = PROD1_W + ENV_W;
    localparam int SCALE_SHIFT = 15 + RAMP_LOG2;

    // tone length in samples = duration * rate / 1000
    localparam int TOTAL_MULT = AUDIO_RATE_HZ / 1000;
    localparam int TOT_W      = DUR_W + $clog2(TOTAL_MULT + 1);
    localparam logic [IDX_W-1:0] TOTAL_MAX = {IDX_W{1'b1}};

    // queue between front and back
    localparam int QUEUE_AW    = 2;
    localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

    // phase step = freq * 2^32 / rate, split as a shift and an odd divisor
    function automatic int rate_tz();
        int n;
        n = 0;
        for (int b = 0; b < 31; b++)
        begin
            if (((AUDIO_RATE_HZ >> b) & 1) == 0 && n == b)
                n = b + 1;
        end
        return n;
    endfunction

    localparam int RATE_TZ  = rate_tz();
    localparam int STEP_DIV = AUDIO_RATE_HZ >> RATE_TZ;

    // freq * 2^STEP_SHIFT / STEP_DIV = freq * STEP_INT + freq * STEP_REM / STEP_DIV
    localparam int STEP_SHIFT = PHASE_W - RATE_TZ;
    localparam int STEP_INT   = (1 << STEP_SHIFT) / STEP_DIV;
    localparam int STEP_REM   = (1 << STEP_SHIFT) - STEP_INT * STEP_DIV;
    localparam int FRAC_W     = $clog2(FREQ_MAX * STEP_REM + 1);

    // exact floor(x / STEP_DIV) for x < 2^FRAC_W by reciprocal multiply
    localparam int RECIP_SHIFT = FRAC_W + $clog2(STEP_DIV);
    localparam int RECIP_MUL   = ((1 << RECIP_SHIFT) + STEP_DIV - 1) / STEP_DIV;
    localparam int RECIP_W     = $clog2(RECIP_MUL + 1);

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef logic [MAG_W-1:0] sine_tbl_t [0:TBL_N];

    // Q15 quarter-wave entry; Taylor series to x^15 in Q30, truncated products
    function automatic logic [MAG_W-1:0] quarter_sine(input int unsigned k);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic signed [63:0] sum;
        logic [63:0] v;
        x    = (64'(k) * HALF_PI_Q30) >> SINE_TABLE_BITS;
        x2   = (x * x) >> 30;
        term = x;
        sum  = $signed(x);
        term = ((term * x2) >> 30) / 64'd6;   sum = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd20;  sum = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd42;  sum = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd72;  sum = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd110; sum = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd156; sum = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd210; sum = sum - $signed(term);
        if (sum < 0)
            sum = 0;
        v = (($unsigned(sum) << 15) + (64'd1 << 29)) >> 30;
        if (v > 64'd32767)
            v = 64'd32767;
        return v[MAG_W-1:0];
    endfunction

    function automatic sine_tbl_t build_sine_tbl();
        sine_tbl_t t;
        for (int k = 0; k <= TBL_N; k++)
        begin
            t[k] = quarter_sine(k);
        end
        return t;
    endfunction

    localparam sine_tbl_t SINE_TBL = build_sine_tbl();

    // one classified word in the queue
    typedef struct packed {
        logic              is_tick;
        logic [FREQ_W-1:0] freq;     // already saturated
        logic [DUR_W-1:0]  dur;
        logic [AMP_W-1:0]  amp;
    } estg_cmd_t;

    // divider result back to the sequencer
    typedef struct packed {
        logic               done;
        logic [PHASE_W-1:0] step;
    } estg_div_stat_t;

endpackage

`default_nettype wire

// ----- src/estg_front.sv -----
`default_nettype none

module estg_front (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         s_axis_tvalid,
    output logic                              s_axis_tready,
    input  wire logic [estg_pkg::IN_BYTES_W-1:0] s_axis_tdata,
    input  wire logic [0:0]                   s_axis_tuser,
    output logic                              cmd_valid,
    input  wire logic                         cmd_pop,
    output estg_pkg::estg_cmd_t               cmd
);
    import estg_pkg::*;

    estg_cmd_t           queue_mem [0:QUEUE_DEPTH-1];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW:0]   count_reg;
    logic [QUEUE_AW:0]   count_next;
    logic                push;
    estg_cmd_t           in_cmd;
    logic [FREQ_W-1:0]   in_freq;

    assign s_axis_tready = (count_reg != (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign push          = s_axis_tvalid && s_axis_tready;
    assign cmd_valid     = (count_reg != '0);
    assign cmd           = queue_mem[rd_ptr_reg];

    // classify and clamp on the way in
    always_comb
    begin
        in_freq = s_axis_tdata[FREQ_W-1:0];
        if (in_freq > FREQ_W'(FREQ_MAX))
            in_freq = FREQ_W'(FREQ_MAX);
        in_cmd.is_tick = (s_axis_tuser[0] == OP_TICK);
        in_cmd.freq    = in_freq;
        in_cmd.dur     = s_axis_tdata[FREQ_W +: DUR_W];
        in_cmd.amp     = s_axis_tdata[FREQ_W+DUR_W +: AMP_W];
    end

    always_comb
    begin
        unique case ({push, cmd_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (cmd_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            queue_mem[wr_ptr_reg] <= in_cmd;
    end

`include "enveloped_sine_tone_generator_top_assert.svh"

    `ESTG_ASSERT_ALWAYS(a_queue_bound, count_reg <= (QUEUE_AW+1)'(QUEUE_DEPTH), "queue overfill")
    `ESTG_ASSERT_IMPL(a_pop_nonempty, cmd_pop, cmd_valid, "pop from empty queue")

endmodule

`default_nettype wire

// ----- src/estg_stepdiv.sv -----
`default_nettype none

// phase step in three stages: integer and remainder parts of freq * 2^(32-tz),
// then the remainder part over the odd divisor by reciprocal multiply
module estg_stepdiv (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [estg_pkg::FREQ_W-1:0] freq,
    output estg_pkg::estg_div_stat_t         stat
);
    import estg_pkg::*;

    logic [FREQ_W-1:0]         freq_reg;
    logic [PHASE_W-1:0]        base_reg;
    logic [FRAC_W-1:0]         frac_num_reg;
    logic [PHASE_W-1:0]        quo_reg;
    logic                      s1_reg;
    logic                      s2_reg;
    logic                      done_reg;
    logic [FRAC_W+RECIP_W-1:0] frac_prod;
    logic [PHASE_W-1:0]        frac;

    always_comb
    begin
        frac_prod = (FRAC_W+RECIP_W)'(frac_num_reg) * (FRAC_W+RECIP_W)'(RECIP_MUL);
        frac      = PHASE_W'(frac_prod >> RECIP_SHIFT);
    end

    assign stat.done = done_reg;
    assign stat.step = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg   <= 1'b0;
            s2_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            s1_reg   <= start;
            s2_reg   <= s1_reg;
            done_reg <= s2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
            freq_reg <= freq;
        if (s1_reg)
        begin
            base_reg     <= PHASE_W'(freq_reg) * PHASE_W'(STEP_INT);
            frac_num_reg <= FRAC_W'(freq_reg) * FRAC_W'(STEP_REM);
        end
        if (s2_reg)
            quo_reg <= base_reg + frac;
    end

`include "enveloped_sine_tone_generator_top_assert.svh"

    `ESTG_ASSERT_ALWAYS(a_one_stage, $onehot0({s1_reg, s2_reg, done_reg}), "overlapping step requests")

endmodule

`default_nettype wire

// ----- src/estg_back.sv -----
`default_nettype none

module estg_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cmd_valid,
    output logic                               cmd_pop,
    input  wire estg_pkg::estg_cmd_t           cmd,
    output logic                               div_start,
    output logic [estg_pkg::FREQ_W-1:0]        div_freq,
    input  wire estg_pkg::estg_div_stat_t      div_stat,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic [estg_pkg::SAMPLE_W-1:0]      m_axis_tdata,
    output logic [0:0]                         m_axis_tuser,
    output logic                               m_axis_tlast
);
    import estg_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_DIV   = 2'd1;
    localparam logic [1:0] ST_MUL   = 2'd2;
    localparam logic [1:0] ST_SCALE = 2'd3;

    logic [1:0]         state_reg;
    logic [1:0]         state_next;

    // tone state
    logic [PHASE_W-1:0] phase_reg;
    logic [PHASE_W-1:0] step_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [IDX_W-1:0]   total_reg;
    logic [AMP_W-1:0]   amp_reg;
    logic               busy_reg;

    // per-sample pipeline
    logic [MAG_W-1:0]   sabs_reg;
    logic               neg_reg;
    logic [ENV_W-1:0]   env_reg;
    logic               act_reg;
    logic               last_reg;
    logic [PROD1_W-1:0] prod1_reg;

    // output register
    logic                out_valid_reg;
    logic [SAMPLE_W-1:0] out_data_reg;
    logic                out_act_reg;
    logic                out_last_reg;

    logic [ENV_W-1:0]    env_c;
    logic [1:0]          quad;
    logic [TBL_AW-1:0]   tidx;
    logic [IDX_W-1:0]    idx_inc;
    logic [TOT_W-1:0]    tot_full;
    logic [IDX_W-1:0]    tot_sat;
    logic [PROD2_W-1:0]  prod2;
    logic [SAMPLE_W-1:0] mag;
    logic [SAMPLE_W-1:0] val;
    logic                out_free;

    assign out_free  = !out_valid_reg || m_axis_tready;
    assign cmd_pop   = (state_reg == ST_IDLE) && cmd_valid;
    assign div_start = cmd_pop && !cmd.is_tick;
    assign div_freq  = cmd.freq;

    // envelope, table address and next index
    always_comb
    begin
        if (idx_reg < IDX_W'(RAMP_SAMPLES))
            env_c = idx_reg[ENV_W-1:0];
        else if (total_reg >= IDX_W'(RAMP_SAMPLES) &&
                 idx_reg > total_reg - IDX_W'(RAMP_SAMPLES))
            env_c = ENV_W'(total_reg - idx_reg);
        else
            env_c = ENV_W'(RAMP_SAMPLES);

        quad = phase_reg[PHASE_W-1 -: 2];
        tidx = {1'b0, phase_reg[PHASE_W-3 -: SINE_TABLE_BITS]};
        if (quad[0])
            tidx = TBL_AW'(TBL_N) - tidx;

        idx_inc  = idx_reg + 1'b1;
        tot_full = TOT_W'(cmd.dur) * TOT_W'(TOTAL_MULT);
        tot_sat  = (tot_full > TOT_W'(TOTAL_MAX)) ? TOTAL_MAX : tot_full[IDX_W-1:0];
    end

    // amplitude * envelope product, then drop Q15 and ramp denominator
    always_comb
    begin
        prod2 = PROD2_W'(prod1_reg) * PROD2_W'(env_reg);
        mag   = prod2[SCALE_SHIFT +: SAMPLE_W];
        if (!act_reg)
            val = '0;
        else if (neg_reg)
            val = SAMPLE_W'(0) - mag;
        else
            val = mag;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (cmd_valid)
                    state_next = cmd.is_tick ? ST_MUL : ST_DIV;
            ST_DIV:
                if (div_stat.done)
                    state_next = ST_IDLE;
            ST_MUL:
                state_next = ST_SCALE;
            ST_SCALE:
                if (out_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= '0;
            step_reg      <= '0;
            idx_reg       <= '0;
            total_reg     <= '0;
            amp_reg       <= '0;
            busy_reg      <= 1'b0;
            act_reg       <= 1'b0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cmd_pop && !cmd.is_tick)
            begin
                total_reg <= tot_sat;
                amp_reg   <= cmd.amp;
                phase_reg <= '0;
                idx_reg   <= '0;
                busy_reg  <= (tot_sat != '0);
            end
            else if (cmd_pop)
            begin
                act_reg  <= busy_reg;
                last_reg <= 1'b0;
                if (busy_reg)
                begin
                    phase_reg <= phase_reg + step_reg;
                    idx_reg   <= idx_inc;
                    if (idx_inc >= total_reg)
                    begin
                        busy_reg <= 1'b0;
                        last_reg <= 1'b1;
                    end
                end
            end

            if (state_reg == ST_DIV && div_stat.done)
                step_reg <= div_stat.step;

            if (state_reg == ST_SCALE && out_free)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop && cmd.is_tick)
        begin
            sabs_reg <= SINE_TBL[tidx];
            neg_reg  <= quad[1];
            env_reg  <= env_c;
        end
        if (state_reg == ST_MUL)
            prod1_reg <= PROD1_W'(sabs_reg) * PROD1_W'(amp_reg);
        if (state_reg == ST_SCALE && out_free)
        begin
            out_data_reg <= val;
            out_act_reg  <= act_reg;
            out_last_reg <= last_reg;
        end
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_data_reg;
    assign m_axis_tuser[0] = out_act_reg;
    assign m_axis_tlast    = out_last_reg;

`include "enveloped_sine_tone_generator_top_assert.svh"

    `ESTG_ASSERT_IMPL(a_idx_in_tone, busy_reg, idx_reg < total_reg, "index past tone end")
    `ESTG_ASSERT_IMPL(a_silence, out_valid_reg && !out_act_reg,
        out_data_reg == '0 && !out_last_reg, "idle word not silent")
    `ESTG_ASSERT_IMPL(a_last_ends, state_reg == ST_SCALE && last_reg, !busy_reg,
        "tone still running after last sample")

endmodule

`default_nettype wire

// ----- src/enveloped_sine_tone_generator_top.sv -----
`default_nettype none

// Enveloped sine tone generator. Input words (tuser = 0 start, 1 tick) enter a
// four-word queue that accepts one word per cycle while it has room; a sequencer
// behind it executes them in order. A start word loads frequency (clamped to
// 8000 Hz), duration (16 samples per ms at 16 kHz) and amplitude, clears phase
// and sample index, and produces no output word; its phase step comes from a
// three-stage reciprocal multiply, and the sequencer waits until it is done.
// A tick runs through the sequencer steps (quarter-wave table lookup and envelope,
// amplitude multiply, envelope multiply) in order and yields one output word: a
// signed sample in tdata, tuser = 1 while a tone plays, tlast on its final sample.
// Ticks with no tone running return zero with tuser and tlast low. The output
// register lets the sequencer prepare a sample while the previous one waits.
// Nothing is swept after reset; the block is ready on the first cycle.
module enveloped_sine_tone_generator_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // tone_freq_hz[12:0], tone_length[28:13], tone_amplitude[43:29], zero pad
    input  wire logic [47:0] s_axis_tdata,
    // opcode[0]
    input  wire logic [0:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // sample_value[15:0]
    output logic [15:0]      m_axis_tdata,
    // tone_active[0]
    output logic [0:0]       m_axis_tuser,
    // last_sample
    output logic             m_axis_tlast
);
    import estg_pkg::*;

    estg_cmd_t         cmd;
    logic              cmd_valid;
    logic              cmd_pop;
    logic              div_start;
    logic [FREQ_W-1:0] div_freq;
    estg_div_stat_t    div_stat;

    // front: takes words, clamps frequency, queues them
    estg_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .cmd_valid     (cmd_valid),
        .cmd_pop       (cmd_pop),
        .cmd           (cmd)
    );

    // phase step unit used by start words
    estg_stepdiv u_stepdiv (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .freq  (div_freq),
        .stat  (div_stat)
    );

    // back: tone state, sample arithmetic, output register
    estg_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (cmd_valid),
        .cmd_pop       (cmd_pop),
        .cmd           (cmd),
        .div_start     (div_start),
        .div_freq      (div_freq),
        .div_stat      (div_stat),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

`default_nettype wire
